[design/tmi_pkg.sv]
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared constants, codes and controller/datapath interface types for the
// tempo map interpolator.
// ----------------------------------------------------------------------------
package tmi_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int FUNC_W      = 2;
	localparam int INDEX_W     = 4;
	localparam int POS_W       = 31;
	localparam int VAL_W       = 32;
	localparam int ENTRY_W     = 2 * POS_W;
	localparam int S_FIELDS_W  = INDEX_W + 2 * POS_W + VAL_W;
	localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = VAL_W;

	localparam int COUNT_REG_W = 5;
	localparam int TOL_W       = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int PROD_W      = 2 * VAL_W;
	localparam int MAG_W       = 2 * POS_W;
	localparam int REM_W       = POS_W + 1;
	localparam int STEP_W      = $clog2(MAG_W);

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_Q2T   = 2'd1,
		FUNC_T2Q   = 2'd2
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENTRY_COUNT = 2'd0,
		CFG_TABLE_AVAIL = 2'd1,
		CFG_SINGLE_TOL  = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_FAIL,
		RES_WRITE,
		RES_SINGLE,
		RES_INTERP
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_CHECK,
		S_SEG,
		S_DIVINIT,
		S_DIV,
		S_SIGN,
		S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     ram_wr;
		logic     ram_rd;
		logic     advance;
		logic     seg_load;
		logic     mul;
		logic     div_init;
		logic     div_step;
		logic     apply_sign;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		func_t func;
		logic  query_ok;
		logic  idx_ok;
		logic  count_one;
		logic  addr_zero;
		logic  addr_last;
		logic  hit;
		logic  delta_zero;
		logic  div_last;
		logic  out_free;
	} dp_status_t;

endpackage

[design/tmi_ram.sv]
// ----------------------------------------------------------------------------
// tmi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/tmi_ctrl.sv]
// ----------------------------------------------------------------------------
// tmi_ctrl
// Sequencer for the interpolator: decode, breakpoint scan, multiply,
// iterative divide, result and output handoff.
// ----------------------------------------------------------------------------
module tmi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tmi_pkg::dp_status_t status,
	output tmi_pkg::ctrl_cmd_t  cmd
);

	tmi_pkg::state_t state_q;
	tmi_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = tmi_pkg::RES_NONE;
		in_ready    = 1'b0;
		case (state_q)
			tmi_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = tmi_pkg::S_DECODE;
				end
			end
			tmi_pkg::S_DECODE: begin
				case (status.func)
					tmi_pkg::FUNC_WRITE: begin
						cmd.ram_wr  = status.idx_ok;
						cmd.res_sel = status.idx_ok ? tmi_pkg::RES_WRITE : tmi_pkg::RES_FAIL;
						state_d     = tmi_pkg::S_DONE;
					end
					tmi_pkg::FUNC_Q2T, tmi_pkg::FUNC_T2Q: begin
						if (status.query_ok) begin
							// entry 0 read goes out now
							cmd.ram_rd = 1'b1;
							state_d    = tmi_pkg::S_CHECK;
						end else begin
							cmd.res_sel = tmi_pkg::RES_FAIL;
							state_d     = tmi_pkg::S_DONE;
						end
					end
					default: begin
						cmd.res_sel = tmi_pkg::RES_FAIL;
						state_d     = tmi_pkg::S_DONE;
					end
				endcase
			end
			tmi_pkg::S_READ: begin
				cmd.ram_rd = 1'b1;
				state_d    = tmi_pkg::S_CHECK;
			end
			tmi_pkg::S_CHECK: begin
				if (status.addr_zero) begin
					if (status.count_one) begin
						cmd.res_sel = tmi_pkg::RES_SINGLE;
						state_d     = tmi_pkg::S_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = tmi_pkg::S_READ;
					end
				end else if (status.hit || status.addr_last) begin
					cmd.seg_load = 1'b1;
					state_d      = tmi_pkg::S_SEG;
				end else begin
					cmd.advance = 1'b1;
					state_d     = tmi_pkg::S_READ;
				end
			end
			tmi_pkg::S_SEG: begin
				if (status.delta_zero) begin
					cmd.res_sel = tmi_pkg::RES_FAIL;
					state_d     = tmi_pkg::S_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = tmi_pkg::S_DIVINIT;
				end
			end
			tmi_pkg::S_DIVINIT: begin
				cmd.div_init = 1'b1;
				state_d      = tmi_pkg::S_DIV;
			end
			tmi_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = tmi_pkg::S_SIGN;
				end
			end
			tmi_pkg::S_SIGN: begin
				cmd.apply_sign = 1'b1;
				state_d        = tmi_pkg::S_FIN;
			end
			tmi_pkg::S_FIN: begin
				cmd.res_sel = tmi_pkg::RES_INTERP;
				state_d     = tmi_pkg::S_DONE;
			end
			tmi_pkg::S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tmi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tmi_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[design/tmi_datapath.sv]
// ----------------------------------------------------------------------------
// tmi_datapath
// Configuration registers, breakpoint table, segment registers, multiplier,
// restoring divider, saturation and the output register.
// ----------------------------------------------------------------------------
module tmi_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmi_pkg::ctrl_cmd_t                  cmd,
	output tmi_pkg::dp_status_t                 status,
	input  logic [tmi_pkg::S_TDATA_W-1:0]       in_data,
	input  logic [tmi_pkg::FUNC_W-1:0]          in_func,
	input  logic                                cfg_valid,
	input  logic [tmi_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tmi_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tmi_pkg::M_TDATA_W-1:0]       out_data,
	output logic                                out_flag
);

	localparam int PW = tmi_pkg::POS_W;
	localparam int VW = tmi_pkg::VAL_W;
	localparam int IW = tmi_pkg::INDEX_W;

	// configuration
	logic [tmi_pkg::COUNT_REG_W-1:0] count_reg_q;
	logic                            avail_q;
	logic [tmi_pkg::TOL_W-1:0]       tol_q;
	logic [tmi_pkg::CNT_W-1:0]       count_eff;

	// captured item
	tmi_pkg::func_t    func_q;
	logic [IW-1:0]     idx_q;
	logic [PW-1:0]     eq_q;
	logic [PW-1:0]     et_q;
	logic [VW-1:0]     q_q;

	// table scan
	logic [tmi_pkg::ADDR_W-1:0]  addr_q;
	logic [tmi_pkg::ENTRY_W-1:0] rd_data;
	logic [PW-1:0]               src_cur;
	logic [PW-1:0]               dst_cur;
	logic [PW-1:0]               prev_src_q;
	logic [PW-1:0]               prev_dst_q;

	// segment and arithmetic
	logic signed [VW-1:0]             diff_in_q;
	logic signed [VW-1:0]             diff_out_q;
	logic signed [VW-1:0]             delta_q;
	logic [PW-1:0]                    a_out_q;
	logic signed [tmi_pkg::PROD_W-1:0] prod_q;
	logic [tmi_pkg::MAG_W-1:0]        num_q;
	logic [PW-1:0]                    den_q;
	logic [PW-1:0]                    rem_q;
	logic                             neg_q;
	logic [tmi_pkg::STEP_W-1:0]       step_q;
	logic signed [tmi_pkg::PROD_W-1:0] quot_q;
	logic [tmi_pkg::REM_W-1:0]        trial;
	logic                             take;
	logic signed [tmi_pkg::PROD_W-1:0] sum;
	logic [VW-1:0]                    sat_val;

	// single-entry match
	logic signed [VW-1:0]       single_d;
	logic [VW-1:0]              single_abs;
	logic [tmi_pkg::TOL_W-1:0]  tol_eff;
	logic                       single_ok;

	// result and output
	logic [VW-1:0] res_val_q;
	logic          res_ok_q;
	logic          out_valid_q;
	logic [VW-1:0] out_val_q;
	logic          out_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg_q <= '0;
			avail_q     <= 1'b0;
			tol_q       <= '0;
		end else if (cfg_valid) begin
			case (tmi_pkg::cfg_index_t'(cfg_index))
				tmi_pkg::CFG_ENTRY_COUNT: count_reg_q <= cfg_data[tmi_pkg::COUNT_REG_W-1:0];
				tmi_pkg::CFG_TABLE_AVAIL: avail_q     <= cfg_data[0];
				tmi_pkg::CFG_SINGLE_TOL:  tol_q       <= cfg_data[tmi_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// counts above the table depth use the whole table
	assign count_eff = (32'(count_reg_q) > tmi_pkg::TABLE_DEPTH) ?
		tmi_pkg::CNT_W'(tmi_pkg::TABLE_DEPTH) : tmi_pkg::CNT_W'(count_reg_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= tmi_pkg::func_t'(in_func);
			idx_q  <= in_data[IW-1:0];
			eq_q   <= in_data[IW+PW-1:IW];
			et_q   <= in_data[IW+2*PW-1:IW+PW];
			q_q    <= in_data[IW+2*PW+VW-1:IW+2*PW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.capture) begin
			addr_q <= '0;
		end else if (cmd.advance) begin
			addr_q <= addr_q + tmi_pkg::ADDR_W'(1);
		end
	end

	tmi_ram #(
		.WIDTH (tmi_pkg::ENTRY_W),
		.DEPTH (tmi_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.ram_wr),
		.wr_addr (tmi_pkg::ADDR_W'(idx_q)),
		.wr_data ({et_q, eq_q}),
		.rd_en   (cmd.ram_rd),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// entry layout: quarter low, time high
	assign src_cur = (func_q == tmi_pkg::FUNC_T2Q) ? rd_data[tmi_pkg::ENTRY_W-1:PW] : rd_data[PW-1:0];
	assign dst_cur = (func_q == tmi_pkg::FUNC_T2Q) ? rd_data[PW-1:0] : rd_data[tmi_pkg::ENTRY_W-1:PW];

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			prev_src_q <= src_cur;
			prev_dst_q <= dst_cur;
		end
		if (cmd.seg_load) begin
			diff_in_q  <= $signed({1'b0, q_q[PW-1:0]}) - $signed({1'b0, prev_src_q});
			diff_out_q <= $signed({1'b0, dst_cur}) - $signed({1'b0, prev_dst_q});
			delta_q    <= $signed({1'b0, src_cur}) - $signed({1'b0, prev_src_q});
			a_out_q    <= prev_dst_q;
		end
		if (cmd.mul) begin
			prod_q <= diff_in_q * diff_out_q;
		end
	end

	// restoring divide on magnitudes, one quotient bit per cycle
	assign trial = {rem_q, num_q[tmi_pkg::MAG_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_init) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + tmi_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			num_q <= prod_q[tmi_pkg::PROD_W-1] ? tmi_pkg::MAG_W'(-prod_q)
				: prod_q[tmi_pkg::MAG_W-1:0];
			den_q <= delta_q[VW-1] ? PW'(-delta_q) : delta_q[PW-1:0];
			neg_q <= prod_q[tmi_pkg::PROD_W-1] ^ delta_q[VW-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= take ? PW'(trial - {1'b0, den_q}) : trial[PW-1:0];
			num_q <= {num_q[tmi_pkg::MAG_W-2:0], take};
		end
		if (cmd.apply_sign) begin
			quot_q <= neg_q ? (tmi_pkg::PROD_W'(0) - tmi_pkg::PROD_W'(num_q))
				: tmi_pkg::PROD_W'(num_q);
		end
	end

	assign sum = quot_q + $signed(tmi_pkg::PROD_W'(a_out_q));

	always_comb begin
		if (!sum[tmi_pkg::PROD_W-1] && (|sum[tmi_pkg::PROD_W-2:VW-1])) begin
			sat_val = tmi_pkg::VAL_MAX;
		end else if (sum[tmi_pkg::PROD_W-1] && !(&sum[tmi_pkg::PROD_W-2:VW-1])) begin
			sat_val = tmi_pkg::VAL_MIN;
		end else begin
			sat_val = sum[VW-1:0];
		end
	end

	assign single_d   = $signed({1'b0, q_q[PW-1:0]}) - $signed({1'b0, src_cur});
	assign single_abs = single_d[VW-1] ? VW'(-single_d) : VW'(single_d);
	assign tol_eff    = (func_q == tmi_pkg::FUNC_Q2T) ? tol_q : '0;
	assign single_ok  = single_abs <= VW'(tol_eff);

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			tmi_pkg::RES_FAIL: begin
				res_val_q <= '0;
				res_ok_q  <= 1'b0;
			end
			tmi_pkg::RES_WRITE: begin
				res_val_q <= '0;
				res_ok_q  <= 1'b1;
			end
			tmi_pkg::RES_SINGLE: begin
				res_val_q <= single_ok ? VW'(dst_cur) : '0;
				res_ok_q  <= single_ok;
			end
			tmi_pkg::RES_INTERP: begin
				res_val_q <= sat_val;
				res_ok_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_val_q <= res_val_q;
			out_ok_q  <= res_ok_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_val_q;
	assign out_flag  = out_ok_q;

	always_comb begin
		status            = '0;
		status.func       = func_q;
		status.query_ok   = avail_q && (count_eff != '0) && !q_q[VW-1];
		status.idx_ok     = 32'(idx_q) < tmi_pkg::TABLE_DEPTH;
		status.count_one  = count_eff == tmi_pkg::CNT_W'(1);
		status.addr_zero  = addr_q == '0;
		status.addr_last  = (tmi_pkg::CNT_W'(addr_q) + tmi_pkg::CNT_W'(1)) == count_eff;
		status.hit        = src_cur >= q_q[PW-1:0];
		status.delta_zero = delta_q == '0;
		status.div_last   = step_q == tmi_pkg::STEP_W'(tmi_pkg::MAG_W - 1);
		status.out_free   = !out_valid_q || out_ready;
	end

endmodule

[design/tempo_map_interpolator.sv]
// Tempo map interpolator: converts quarter positions to time and back by
// linear interpolation over a breakpoint table, one item at a time. A query
// rejected up front (table unavailable or empty, negative value), a write, a
// lone-entry lookup and a zero-length segment all finish without a divide.
// The table sits in a single-read RAM scanned one entry at a time, and the
// quotient comes from a restoring divider that makes one bit per cycle,
// which sets most of the query time. The finished result waits in an output
// register, so the next item is taken as soon as the previous result has
// moved there.
// ----------------------------------------------------------------------------
// tempo_map_interpolator
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module tempo_map_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	// cfg_index: 0 entry_count, 1 table_available, 2 single_point_tolerance
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tmi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tmi_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// entry_index[3:0], entry_quarter[34:4], entry_time[65:35], query_value[97:66]
	input  logic [tmi_pkg::S_TDATA_W-1:0]      s_tdata,
	// func[1:0]
	input  logic [tmi_pkg::FUNC_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// mapped_value[31:0]
	output logic [tmi_pkg::M_TDATA_W-1:0]      m_tdata,
	// result_valid[0]
	output logic                               m_tuser
);

	tmi_pkg::ctrl_cmd_t  cmd;
	tmi_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	tmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tmi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.in_func   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_flag  (m_tuser)
	);

endmodule

[design/tmi_checker.sv]
// ----------------------------------------------------------------------------
// tmi_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tmi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tmi_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	// no result is offered while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// failed conversions and failed writes carry zero data when not valid
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid result with nonzero value");

	// one item in flight: input closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

endmodule

bind tempo_map_interpolator tmi_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
